>>> sv/tgd_pkg.sv
// ----------------------------------------------------------------------------
// tgd_pkg: shared constants, types and helpers
// widths, register codes and the multiply op word of the tone detector
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int MAX_RESET_LENGTH = 4096;
  localparam int COEF_FRAC_BITS   = 14;
  localparam int ACC_BITS         = 48;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 17;
  localparam int RLEN_W   = 13;
  localparam int NPOW_W   = 16;
  localparam int ENERGY_W = 44;

  localparam int COUNT_W   = $clog2(2 * MAX_RESET_LENGTH);
  localparam int PHASE_W   = COUNT_W;
  localparam int COUNT_MAX = 2 * MAX_RESET_LENGTH - 1;
  localparam int COEF_LIM  = 1 << (COEF_FRAC_BITS + 1);

  // shared multiplier: wide operand times one digit per cycle
  localparam int CMAG_W  = COEF_FRAC_BITS + 2;
  localparam int DIG_W   = CMAG_W;
  localparam int NDIG    = (ACC_BITS + DIG_W - 1) / DIG_W;
  localparam int DIG_CW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int A_W     = CMAG_W + ACC_BITS;
  localparam int MUL_W   = A_W + DIG_W;
  localparam int PROD_W  = A_W + DIG_W * NDIG;

  localparam int SQ_W    = 2 * SAMPLE_W - 1;
  localparam int SUMSQ_W = 2 * ACC_BITS;
  localparam int NUM_W   = SUMSQ_W + COEF_FRAC_BITS + 2;
  localparam int QUO_W   = NPOW_W;
  localparam int REM_W   = NUM_W + QUO_W;
  localparam int DEN_W   = ENERGY_W + COUNT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COEF_W;
  localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LENGTH = 2'd1;

  localparam logic [ACC_BITS-1:0] ACC_POS_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};

  typedef struct packed {
    logic              en;
    logic              clear;
    logic [A_W-1:0]    a;
    logic [DIG_W-1:0]  digit;
    logic [DIG_CW-1:0] k;
  } mac_op_t;

  function automatic logic [ACC_BITS-1:0] acc_mag(input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] n;
    n = -v;
    return v[ACC_BITS-1] ? ACC_BITS'(n) : ACC_BITS'(v);
  endfunction

  // clamp a two-bit-wider sum to the signed delay range
  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS+1:0] v);
    logic same;
    same = (v[ACC_BITS+1:ACC_BITS-1] == 3'b000) || (v[ACC_BITS+1:ACC_BITS-1] == 3'b111);
    if (same) return v[ACC_BITS-1:0];
    else if (v[ACC_BITS+1]) return ~ACC_POS_MAX;
    else return ACC_POS_MAX;
  endfunction

endpackage

>>> sv/tgd_mac.sv
// ----------------------------------------------------------------------------
// tgd_mac: shared digit multiply-accumulate unit
// adds a times one digit, placed at digit position k, into the accumulator
// ----------------------------------------------------------------------------
module tgd_mac import tgd_pkg::*; (
  input  logic              clk,
  input  mac_op_t           op,
  output logic [PROD_W-1:0] acc
);

  logic [MUL_W-1:0]  pr;
  logic [PROD_W-1:0] term;

  assign pr   = op.a * op.digit;
  assign term = PROD_W'(pr) << (DIG_W * op.k);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= (op.clear ? '0 : acc) + term;
    end
  end

endmodule

>>> sv/tgd_div.sv
// ----------------------------------------------------------------------------
// tgd_div: restoring divider for the normalized power
// one saturation check, then one quotient bit per cycle
// ----------------------------------------------------------------------------
module tgd_div import tgd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(QUO_W + 1);
  localparam logic [CNT_W-1:0] SAT_STEP = CNT_W'(QUO_W);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      done <= (den == '0);
      busy <= (den != '0);
      quo  <= '0;
      rem  <= {num, QUO_W'(0)};
      dsh  <= REM_W'(den) << (COEF_FRAC_BITS + QUO_W);
      cnt  <= SAT_STEP;
    end else if (busy) begin
      if (cnt == SAT_STEP) begin
        if (ge) begin
          quo  <= '1;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          dsh <= dsh >> 1;
          cnt <= cnt - 1'b1;
        end
      end else begin
        quo <= {quo[QUO_W-2:0], ge};
        if (ge) begin
          rem <= rem - dsh;
        end
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/tandem_goertzel_tone_detector.sv
// ----------------------------------------------------------------------------
// tandem_goertzel_tone_detector: two-bank sliding goertzel tone detector
// each accepted sample passes through the shared 64x16 multiply-accumulate and
//   then the bit-serial divider (one saturation check plus 16 quotient bits)
// input: a new sample is accepted only after the last word has moved to the
//   output register; in_ready only when idle
// reset: banks, phase and output valid cleared, coefficient 0, reset length 512
// ----------------------------------------------------------------------------
module tandem_goertzel_tone_detector import tgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NPOW_W-1:0]     normalized_power,
  output logic                  active_bank,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_MC, ST_UPD, ST_PH, ST_CLR, ST_EN, ST_P1, ST_P2,
    ST_CD, ST_CDH, ST_CDD, ST_NUM, ST_DEN, ST_DIV
  } state_t;

  localparam logic [DIG_CW-1:0] LAST_DIG = DIG_CW'(NDIG - 1);

  state_t state;

  // config registers
  logic signed [COEF_W-1:0] coef;
  logic [RLEN_W-1:0]        rlen;

  // bank state
  logic signed [ACC_BITS-1:0] d1 [2];
  logic signed [ACC_BITS-1:0] d2 [2];
  logic [ENERGY_W-1:0]        energy [2];
  logic [COUNT_W-1:0]         count [2];
  logic [PHASE_W-1:0]         phase;

  // per-word working registers
  logic signed [SAMPLE_W-1:0] x;
  logic [SQ_W-1:0]            sq;
  logic [SUMSQ_W-1:0]         sumsq;
  logic [A_W-1:0]             cd;
  logic [NUM_W-1:0]           num;
  logic                       bidx;
  logic                       act;
  logic [DIG_CW-1:0]          dig;

  mac_op_t            mac_op;
  logic [PROD_W-1:0]  acc;
  logic [QUO_W-1:0]   quo;
  logic               div_done;
  logic               div_start;
  logic               out_load;

  // clamped coefficient and reset length
  logic signed [COEF_W-1:0] c_cl;
  logic signed [COEF_W-1:0] c_neg;
  logic [CMAG_W-1:0]        cmag;
  logic                     cneg;
  logic [RLEN_W-1:0]        rc;

  always_comb begin
    if (coef > $signed(COEF_W'(COEF_LIM))) c_cl = $signed(COEF_W'(COEF_LIM));
    else if (coef < -$signed(COEF_W'(COEF_LIM))) c_cl = -$signed(COEF_W'(COEF_LIM));
    else c_cl = coef;
    c_neg = -c_cl;
    cneg  = c_cl[COEF_W-1];
    cmag  = cneg ? CMAG_W'(c_neg) : CMAG_W'(c_cl);
    if (rlen == '0) rc = RLEN_W'(1);
    else if (rlen > RLEN_W'(MAX_RESET_LENGTH)) rc = RLEN_W'(MAX_RESET_LENGTH);
    else rc = rlen;
  end

  // magnitudes of the selected bank and the sample
  logic [ACC_BITS-1:0]        dmag1;
  logic [ACC_BITS-1:0]        dmag2;
  logic signed [SAMPLE_W-1:0] x_neg;
  logic [SAMPLE_W-1:0]        xmag;

  assign dmag1 = acc_mag(d1[bidx]);
  assign dmag2 = acc_mag(d2[bidx]);
  assign x_neg = -x;
  assign xmag  = x[SAMPLE_W-1] ? SAMPLE_W'(x_neg) : SAMPLE_W'(x);

  // resonator update: round coef*d1 half away from zero, saturate, add x, sub d2
  localparam int QW1 = A_W + 1 - COEF_FRAC_BITS;
  logic [A_W:0]               rnd;
  logic [QW1-1:0]             q_rnd;
  logic [QW1-1:0]             q_lim;
  logic [ACC_BITS-1:0]        q_sat;
  logic                       m_neg;
  logic signed [ACC_BITS-1:0] m;
  logic signed [ACC_BITS+1:0] t_sum;
  logic signed [ACC_BITS-1:0] t_cl;
  logic signed [ACC_BITS+1:0] u_sum;
  logic signed [ACC_BITS-1:0] s_new;

  always_comb begin
    m_neg = cneg ^ d1[bidx][ACC_BITS-1];
    rnd   = {1'b0, acc[A_W-1:0]} + (A_W + 1)'(1 << (COEF_FRAC_BITS - 1));
    q_rnd = rnd[A_W:COEF_FRAC_BITS];
    q_lim = QW1'(ACC_POS_MAX) + QW1'(m_neg);
    q_sat = (q_rnd > q_lim) ? q_lim[ACC_BITS-1:0] : q_rnd[ACC_BITS-1:0];
    m     = m_neg ? -$signed(q_sat) : $signed(q_sat);
    t_sum = (ACC_BITS + 2)'(x) + (ACC_BITS + 2)'(m);
    t_cl  = sat_acc(t_sum);
    u_sum = (ACC_BITS + 2)'(t_cl) - (ACC_BITS + 2)'(d2[bidx]);
    s_new = sat_acc(u_sum);
  end

  // phase advance and bank select
  logic [PHASE_W:0] ph_inc;
  logic [PHASE_W:0] ph_next;
  logic             act_new;

  always_comb begin
    ph_inc  = {1'b0, phase} + 1'b1;
    ph_next = (ph_inc >= {rc, 1'b0}) ? '0 : ph_inc;
    act_new = (ph_next >= (PHASE_W + 1)'(rc));
  end

  // energy accumulate with saturation
  logic [ENERGY_W:0] e_sum0;
  logic [ENERGY_W:0] e_sum1;

  assign e_sum0 = {1'b0, energy[0]} + (ENERGY_W + 1)'(sq);
  assign e_sum1 = {1'b0, energy[1]} + (ENERGY_W + 1)'(sq);

  // numerator: (d1^2 + d2^2) << frac minus signed coef*d1*d2, floored at zero
  logic [NUM_W-1:0] a_term;
  logic [NUM_W-1:0] p_term;
  logic             prod_pos;
  logic [NUM_W-1:0] num_new;

  always_comb begin
    a_term   = NUM_W'(sumsq) << COEF_FRAC_BITS;
    p_term   = NUM_W'(acc);
    prod_pos = ~(cneg ^ d1[bidx][ACC_BITS-1] ^ d2[bidx][ACC_BITS-1]);
    if (!prod_pos) num_new = a_term + p_term;
    else if (a_term >= p_term) num_new = a_term - p_term;
    else num_new = '0;
  end

  // op word for the shared multiplier
  always_comb begin
    mac_op = '0;
    unique case (state)
      ST_SQ: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = A_W'(xmag);
        mac_op.digit = DIG_W'(xmag);
      end
      ST_MC, ST_CD: begin
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = A_W'(dmag1);
        mac_op.digit = DIG_W'(cmag);
      end
      ST_P1: begin
        mac_op.en    = 1'b1;
        mac_op.clear = (dig == '0);
        mac_op.a     = A_W'(dmag1);
        mac_op.digit = dmag1[DIG_W*dig +: DIG_W];
        mac_op.k     = dig;
      end
      ST_P2: begin
        mac_op.en    = 1'b1;
        mac_op.a     = A_W'(dmag2);
        mac_op.digit = dmag2[DIG_W*dig +: DIG_W];
        mac_op.k     = dig;
      end
      ST_CDD: begin
        mac_op.en    = 1'b1;
        mac_op.clear = (dig == '0);
        mac_op.a     = cd;
        mac_op.digit = dmag2[DIG_W*dig +: DIG_W];
        mac_op.k     = dig;
      end
      ST_NUM: begin
        // energy times count of the active bank
        mac_op.en    = 1'b1;
        mac_op.clear = 1'b1;
        mac_op.a     = A_W'(energy[bidx]);
        mac_op.digit = DIG_W'(count[bidx]);
      end
      default: mac_op = '0;
    endcase
  end

  tgd_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  assign div_start = (state == ST_DEN);

  tgd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (acc[DEN_W-1:0]),
    .quo   (quo),
    .done  (div_done)
  );

  assign in_ready  = (state == ST_IDLE);
  // registers change only between words
  assign cfg_ready = (state == ST_IDLE);

  // finished word moves into the output register when it is free
  assign out_load = (state == ST_DIV) && div_done && (!out_valid || out_ready);

  // sequencer, bank state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      coef      <= '0;
      rlen      <= RLEN_W'(512);
      phase     <= '0;
      bidx      <= 1'b0;
      act       <= 1'b0;
      dig       <= '0;
      for (int b = 0; b < 2; b++) begin
        d1[b]     <= '0;
        d2[b]     <= '0;
        energy[b] <= '0;
        count[b]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_COEFFICIENT:  coef <= $signed(cfg_data[COEF_W-1:0]);
          REG_RESET_LENGTH: rlen <= cfg_data[RLEN_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            x     <= $signed(sample);
            bidx  <= 1'b0;
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_MC;
        ST_MC: begin
          if (!bidx) begin
            sq <= acc[SQ_W-1:0];
          end
          state <= ST_UPD;
        end
        ST_UPD: begin
          d2[bidx] <= d1[bidx];
          d1[bidx] <= s_new;
          if (count[bidx] < COUNT_W'(COUNT_MAX)) begin
            count[bidx] <= count[bidx] + 1'b1;
          end
          if (bidx) begin
            state <= ST_PH;
          end else begin
            bidx  <= 1'b1;
            state <= ST_MC;
          end
        end
        ST_PH: begin
          phase <= ph_next[PHASE_W-1:0];
          act   <= act_new;
          bidx  <= ~act_new;
          state <= ST_CLR;
        end
        ST_CLR: begin
          // idle bank restarts once it has run a full period
          if (count[bidx] >= COUNT_W'(rc)) begin
            d1[bidx]     <= '0;
            d2[bidx]     <= '0;
            energy[bidx] <= '0;
            count[bidx]  <= '0;
          end
          bidx  <= act;
          state <= ST_EN;
        end
        ST_EN: begin
          energy[0] <= e_sum0[ENERGY_W] ? '1 : e_sum0[ENERGY_W-1:0];
          energy[1] <= e_sum1[ENERGY_W] ? '1 : e_sum1[ENERGY_W-1:0];
          dig       <= '0;
          state     <= ST_P1;
        end
        ST_P1: begin
          if (dig == LAST_DIG) begin
            dig   <= '0;
            state <= ST_P2;
          end else begin
            dig <= dig + 1'b1;
          end
        end
        ST_P2: begin
          if (dig == LAST_DIG) begin
            dig   <= '0;
            state <= ST_CD;
          end else begin
            dig <= dig + 1'b1;
          end
        end
        ST_CD: begin
          sumsq <= acc[SUMSQ_W-1:0];
          state <= ST_CDH;
        end
        ST_CDH: begin
          cd    <= acc[A_W-1:0];
          dig   <= '0;
          state <= ST_CDD;
        end
        ST_CDD: begin
          if (dig == LAST_DIG) begin
            dig   <= '0;
            state <= ST_NUM;
          end else begin
            dig <= dig + 1'b1;
          end
        end
        ST_NUM: begin
          num   <= num_new;
          state <= ST_DEN;
        end
        ST_DEN: state <= ST_DIV;
        ST_DIV: begin
          // hold the finished word until the output register is free
          if (out_load) begin
            normalized_power <= quo;
            active_bank      <= act;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a new word is never taken back to back
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

  // results only appear out of the divide step
  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DIV)
    else $error("output loaded outside divide step");

  // a blocked output stalls the sequencer in the divide step
  a_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && out_valid && !out_ready |=> state == ST_DIV)
    else $error("sequencer left divide step while output blocked");

endmodule
